// File: hdl/pvrg_pkg.sv
// Shared types, widths and register codes for the pinhole view ray generator.
`timescale 1ns / 1ps

package pvrg_pkg;

  localparam int COORD_BITS  = 16;
  localparam int CORNER_W    = 3 * COORD_BITS;
  localparam int DIM_W       = 13;
  localparam int PIX_W       = 12;
  localparam int DIR_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int MAX_DIM_DEF = 4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOP_LEFT    = 3'd0,
    REG_TOP_RIGHT   = 3'd1,
    REG_BOTTOM_LEFT = 3'd2,
    REG_EYE         = 3'd3,
    REG_WIDTH       = 3'd4,
    REG_HEIGHT      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_row;
  } in_word_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic                    degenerate;
  } out_word_t;

endpackage

// File: hdl/pvrg_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module pvrg_div #(
  parameter int NUM_W  = 28,
  parameter int DEN_W  = 13,
  parameter int Q_W    = 28,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_r  [Q_W+1];
  logic [DEN_W-1:0]  rem_r  [Q_W+1];
  logic [Q_W-1:0]    w_r    [Q_W+1];
  logic [DEN_W-1:0]  den_r  [Q_W+1];
  logic [SIDE_W-1:0] side_r [Q_W+1];
  logic [DEN_W-1:0]  rem_init;

  // upper numerator bits seed the remainder; they stay below the divisor
  if (NUM_W > Q_W) begin : g_seed
    assign rem_init = DEN_W'(num_i[NUM_W-1:Q_W]);
  end else begin : g_noseed
    assign rem_init = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= valid_i;
    end
    rem_r[0]  <= rem_init;
    w_r[0]    <= num_i[Q_W-1:0];
    den_r[0]  <= den_i;
    side_r[0] <= side_i;
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    assign trial = {rem_r[s], w_r[s][Q_W-1]};
    assign diff  = trial - {1'b0, den_r[s]};
    assign ge    = trial >= {1'b0, den_r[s]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
      rem_r[s+1]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      w_r[s+1]    <= {w_r[s][Q_W-2:0], ge};
      den_r[s+1]  <= den_r[s];
      side_r[s+1] <= side_r[s];
    end
  end

  assign valid_o = vld_r[Q_W];
  assign quo_o   = w_r[Q_W];
  assign side_o  = side_r[Q_W];

endmodule

// File: hdl/pvrg_isqrt.sv
// Pipelined 64-bit integer square root, one root bit per stage.
`timescale 1ns / 1ps

module pvrg_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  input  logic [63:0]       rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [31:0]       root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int STEPS = 32;

  logic              vld_r  [STEPS+1];
  logic [63:0]       n_r    [STEPS+1];
  logic [63:0]       r_r    [STEPS+1];
  logic [SIDE_W-1:0] side_r [STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= valid_i;
    end
    n_r[0]    <= rad_i;
    r_r[0]    <= '0;
    side_r[0] <= side_i;
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * s);
    logic [63:0] trial;
    logic        ge;

    assign trial = r_r[s] + BIT;
    assign ge    = n_r[s] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
      n_r[s+1]    <= ge ? n_r[s] - trial : n_r[s];
      r_r[s+1]    <= ge ? (r_r[s] >> 1) + BIT : r_r[s] >> 1;
      side_r[s+1] <= side_r[s];
    end
  end

  assign valid_o = vld_r[STEPS];
  assign root_o  = r_r[STEPS][31:0];
  assign side_o  = side_r[STEPS];

endmodule

// File: hdl/pinhole_view_ray_generator.sv
// Top level: pinhole camera primary ray direction pipeline.
`timescale 1ns / 1ps

// Takes one pixel word per clock and returns one unit ray direction word per
// pixel, in order. The block never stalls: busy stays low, and each result
// shows on out_data for exactly one cycle with out_valid high, so the receiver
// must take it then. The latency is set by the two pixel ratio dividers (one
// quotient bit per stage, 28 stages), the 32 stage square root for the vector
// length and the 15 stage dividers that scale each component to unit length,
// plus the product, normalize and square stages between them. Write configuration
// only while no pixel is in flight; cfg_ready is always high. Corner and eye
// registers pack signed Q8.8 x, y, z in bits 15:0, 31:16, 47:32; width and
// height of zero act as one and are capped at MAX_DIM. A zero length view
// vector returns a zero direction with degenerate set.
module pinhole_view_ray_generator
  import pvrg_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_word_t             in_data,
  output logic                 out_valid,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CORNER_W-1:0]  cfg_data
);

  localparam int RX_W      = PIX_W + 16;          // ratio with 16 fraction bits
  localparam int DIFF_W    = COORD_BITS + 1;
  localparam int PROD_W    = DIFF_W + RX_W + 1;
  localparam int V_W       = 48;
  localparam int NRM_W     = 31;
  localparam int QN_W      = 15;
  localparam int NUM_W     = NRM_W + 15;
  localparam int GRP       = V_W / 8;
  localparam int SIDE_ISQ  = 1 + 3 + 3 * NRM_W;
  localparam int LAT_RX    = RX_W + 1;
  localparam int LAT_ISQ   = 33;
  localparam int LAT_QN    = QN_W + 1;
  localparam int LAT       = 1 + LAT_RX + 8 + LAT_ISQ + 1 + LAT_QN + 1;

  logic accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CORNER_W-1:0] tl_r, tr_r, bl_r, eye_r;
  logic [DIM_W-1:0]    wid_r, hgt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tl_r  <= '0;
      tr_r  <= '0;
      bl_r  <= '0;
      eye_r <= '0;
      wid_r <= DIM_W'(640);
      hgt_r <= DIM_W'(480);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TOP_LEFT:    tl_r  <= cfg_data;
        REG_TOP_RIGHT:   tr_r  <= cfg_data;
        REG_BOTTOM_LEFT: bl_r  <= cfg_data;
        REG_EYE:         eye_r <= cfg_data;
        REG_WIDTH:       wid_r <= cfg_data[DIM_W-1:0];
        REG_HEIGHT:      hgt_r <= cfg_data[DIM_W-1:0];
        default: ;       // drop writes to unused indexes
      endcase
    end
  end

  // Derived configuration: clamped divisors and per-axis corner differences.
  // These follow the registers in the next cycle and hold while pixels flow.
  logic [DIM_W-1:0]         cw_r, cw_nxt, ch_r, ch_nxt;
  logic signed [DIFF_W-1:0] a_r [3];
  logic signed [DIFF_W-1:0] b_r [3];
  logic signed [DIFF_W-1:0] c_r [3];
  logic signed [DIFF_W-1:0] a_nxt [3];
  logic signed [DIFF_W-1:0] b_nxt [3];
  logic signed [DIFF_W-1:0] c_nxt [3];

  always_comb begin
    logic signed [COORD_BITS-1:0] tl, tr, bl, ey;
    if (wid_r == '0)                          cw_nxt = DIM_W'(1);
    else if (32'(wid_r) > MAX_DIM)            cw_nxt = DIM_W'(MAX_DIM);
    else                                      cw_nxt = wid_r;
    if (hgt_r == '0)                          ch_nxt = DIM_W'(1);
    else if (32'(hgt_r) > MAX_DIM)            ch_nxt = DIM_W'(MAX_DIM);
    else                                      ch_nxt = hgt_r;
    for (int i = 0; i < 3; i++) begin
      tl = $signed(tl_r[COORD_BITS*i +: COORD_BITS]);
      tr = $signed(tr_r[COORD_BITS*i +: COORD_BITS]);
      bl = $signed(bl_r[COORD_BITS*i +: COORD_BITS]);
      ey = $signed(eye_r[COORD_BITS*i +: COORD_BITS]);
      a_nxt[i] = DIFF_W'(tl) - DIFF_W'(ey);
      b_nxt[i] = DIFF_W'(tr) - DIFF_W'(tl);
      c_nxt[i] = DIFF_W'(bl) - DIFF_W'(tl);
    end
  end

  always_ff @(posedge clk) begin
    cw_r <= cw_nxt;
    ch_r <= ch_nxt;
    for (int i = 0; i < 3; i++) begin
      a_r[i] <= a_nxt[i];
      b_r[i] <= b_nxt[i];
      c_r[i] <= c_nxt[i];
    end
  end

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic             v0_r;
  logic [PIX_W-1:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
    px_r <= in_data.pixel_col;
    py_r <= in_data.pixel_row;
  end

  // ---------------------------------------------------------------------
  // Pixel ratios x*2^16/W and y*2^16/H
  // ---------------------------------------------------------------------
  logic            rx_vld;
  logic [RX_W-1:0] rx_q, ry_q;

  pvrg_div #(
    .NUM_W (RX_W),
    .DEN_W (DIM_W),
    .Q_W   (RX_W),
    .SIDE_W(1)
  ) u_div_rx (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid_i(v0_r),
    .num_i  ({px_r, 16'd0}),
    .den_i  (cw_r),
    .side_i (1'b0),
    .valid_o(rx_vld),
    .quo_o  (rx_q),
    .side_o ()
  );

  pvrg_div #(
    .NUM_W (RX_W),
    .DEN_W (DIM_W),
    .Q_W   (RX_W),
    .SIDE_W(1)
  ) u_div_ry (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid_i(v0_r),
    .num_i  ({py_r, 16'd0}),
    .den_i  (ch_r),
    .side_i (1'b0),
    .valid_o(),
    .quo_o  (ry_q),
    .side_o ()
  );

  // ---------------------------------------------------------------------
  // Products, then the view vector sum
  // ---------------------------------------------------------------------
  logic                     p1_vld_r;
  logic signed [PROD_W-1:0] pb_r [3];
  logic signed [PROD_W-1:0] pc_r [3];
  logic signed [V_W-1:0]    pa_r [3];
  logic signed [RX_W:0]     rx_s, ry_s;

  assign rx_s = $signed({1'b0, rx_q});
  assign ry_s = $signed({1'b0, ry_q});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= rx_vld;
    end
    for (int i = 0; i < 3; i++) begin
      // widen before the multiply so the full product is kept
      pb_r[i] <= PROD_W'(b_r[i]) * rx_s;
      pc_r[i] <= PROD_W'(c_r[i]) * ry_s;
      pa_r[i] <= V_W'($signed({a_r[i], 16'd0}));
    end
  end

  logic                  p2_vld_r;
  logic signed [V_W-1:0] v_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else begin
      p2_vld_r <= p1_vld_r;
    end
    for (int i = 0; i < 3; i++) begin
      v_r[i] <= pa_r[i] + V_W'(pb_r[i]) + V_W'(pc_r[i]);
    end
  end

  // ---------------------------------------------------------------------
  // Magnitudes and signs
  // ---------------------------------------------------------------------
  logic           p3_vld_r;
  logic [V_W-1:0] mag_r [3];
  logic [2:0]     neg3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else begin
      p3_vld_r <= p2_vld_r;
    end
    for (int i = 0; i < 3; i++) begin
      neg3_r[i] <= v_r[i][V_W-1];
      mag_r[i]  <= v_r[i][V_W-1] ? V_W'(-v_r[i]) : V_W'(v_r[i]);
    end
  end

  // ---------------------------------------------------------------------
  // Leading one search: per byte, then across bytes. The top bit of the OR of
  // the magnitudes is the top bit of the largest one.
  // ---------------------------------------------------------------------
  logic           p4_vld_r;
  logic [V_W-1:0] mag4_r [3];
  logic [2:0]     neg4_r;
  logic [GRP-1:0] any_r, any_nxt;
  logic [2:0]     pos_r [GRP];
  logic [2:0]     pos_nxt [GRP];

  always_comb begin
    logic [V_W-1:0] orv;
    orv = mag_r[0] | mag_r[1] | mag_r[2];
    for (int g = 0; g < GRP; g++) begin
      any_nxt[g] = |orv[8*g +: 8];
      pos_nxt[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (orv[8*g+b]) pos_nxt[g] = 3'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_vld_r <= 1'b0;
    end else begin
      p4_vld_r <= p3_vld_r;
    end
    any_r  <= any_nxt;
    neg4_r <= neg3_r;
    for (int i = 0; i < 3; i++) mag4_r[i] <= mag_r[i];
    for (int g = 0; g < GRP; g++) pos_r[g] <= pos_nxt[g];
  end

  logic           p5_vld_r;
  logic [V_W-1:0] mag5_r [3];
  logic [2:0]     neg5_r;
  logic [5:0]     top_r, top_nxt;
  logic           deg5_r;

  always_comb begin
    top_nxt = '0;
    for (int g = 0; g < GRP; g++) begin
      if (any_r[g]) top_nxt = {3'(g), pos_r[g]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_vld_r <= 1'b0;
    end else begin
      p5_vld_r <= p4_vld_r;
    end
    top_r  <= top_nxt;
    deg5_r <= (any_r == '0);
    neg5_r <= neg4_r;
    for (int i = 0; i < 3; i++) mag5_r[i] <= mag4_r[i];
  end

  // ---------------------------------------------------------------------
  // Normalize so the largest magnitude has its top bit at bit 30
  // ---------------------------------------------------------------------
  localparam logic [5:0] TOP_POS = 6'(NRM_W - 1);

  logic             p6_vld_r;
  logic [NRM_W-1:0] nm_r [3];
  logic [2:0]       neg6_r;
  logic             deg6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p6_vld_r <= 1'b0;
    end else begin
      p6_vld_r <= p5_vld_r;
    end
    neg6_r <= neg5_r;
    deg6_r <= deg5_r;
    for (int i = 0; i < 3; i++) begin
      if (top_r >= TOP_POS) begin
        nm_r[i] <= NRM_W'(mag5_r[i] >> (top_r - TOP_POS));
      end else begin
        nm_r[i] <= NRM_W'(mag5_r[i] << (TOP_POS - top_r));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Squares, then their sum
  // ---------------------------------------------------------------------
  logic               p7_vld_r;
  logic [2*NRM_W-1:0] sq_r [3];
  logic [NRM_W-1:0]   nm7_r [3];
  logic [2:0]         neg7_r;
  logic               deg7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p7_vld_r <= 1'b0;
    end else begin
      p7_vld_r <= p6_vld_r;
    end
    neg7_r <= neg6_r;
    deg7_r <= deg6_r;
    for (int i = 0; i < 3; i++) begin
      sq_r[i]  <= (2*NRM_W)'(nm_r[i]) * nm_r[i];
      nm7_r[i] <= nm_r[i];
    end
  end

  logic                p8_vld_r;
  logic [63:0]         ssq_r;
  logic [SIDE_ISQ-1:0] side8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p8_vld_r <= 1'b0;
    end else begin
      p8_vld_r <= p7_vld_r;
    end
    ssq_r   <= 64'(sq_r[0]) + 64'(sq_r[1]) + 64'(sq_r[2]);
    side8_r <= {deg7_r, neg7_r, nm7_r[2], nm7_r[1], nm7_r[0]};
  end

  // ---------------------------------------------------------------------
  // Vector length
  // ---------------------------------------------------------------------
  logic                isq_vld;
  logic [31:0]         len;
  logic [SIDE_ISQ-1:0] isq_side;

  pvrg_isqrt #(
    .SIDE_W(SIDE_ISQ)
  ) u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid_i(p8_vld_r),
    .rad_i  (ssq_r),
    .side_i (side8_r),
    .valid_o(isq_vld),
    .root_o (len),
    .side_o (isq_side)
  );

  // ---------------------------------------------------------------------
  // Rounded scale numerators |c|*2^14 + L/2
  // ---------------------------------------------------------------------
  logic             p9_vld_r;
  logic [NUM_W-1:0] num_r [3];
  logic [31:0]      len9_r;
  logic [2:0]       neg9_r;
  logic             deg9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p9_vld_r <= 1'b0;
    end else begin
      p9_vld_r <= isq_vld;
    end
    len9_r <= len;
    deg9_r <= isq_side[SIDE_ISQ-1];
    neg9_r <= isq_side[3*NRM_W +: 3];
    for (int i = 0; i < 3; i++) begin
      num_r[i] <= NUM_W'({isq_side[NRM_W*i +: NRM_W], 14'd0}) + NUM_W'(len[31:1]);
    end
  end

  // ---------------------------------------------------------------------
  // Scale each component by the length
  // ---------------------------------------------------------------------
  logic            qx_vld;
  logic [QN_W-1:0] qx, qy, qz;
  logic [1:0]      qx_side;
  logic            qy_neg, qz_neg;

  pvrg_div #(
    .NUM_W (NUM_W),
    .DEN_W (32),
    .Q_W   (QN_W),
    .SIDE_W(2)
  ) u_div_nx (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid_i(p9_vld_r),
    .num_i  (num_r[0]),
    .den_i  (len9_r),
    .side_i ({deg9_r, neg9_r[0]}),
    .valid_o(qx_vld),
    .quo_o  (qx),
    .side_o (qx_side)
  );

  pvrg_div #(
    .NUM_W (NUM_W),
    .DEN_W (32),
    .Q_W   (QN_W),
    .SIDE_W(1)
  ) u_div_ny (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid_i(p9_vld_r),
    .num_i  (num_r[1]),
    .den_i  (len9_r),
    .side_i (neg9_r[1]),
    .valid_o(),
    .quo_o  (qy),
    .side_o (qy_neg)
  );

  pvrg_div #(
    .NUM_W (NUM_W),
    .DEN_W (32),
    .Q_W   (QN_W),
    .SIDE_W(1)
  ) u_div_nz (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid_i(p9_vld_r),
    .num_i  (num_r[2]),
    .den_i  (len9_r),
    .side_i (neg9_r[2]),
    .valid_o(),
    .quo_o  (qz),
    .side_o (qz_neg)
  );

  // ---------------------------------------------------------------------
  // Output register: apply signs, force zero on a degenerate vector
  // ---------------------------------------------------------------------
  logic      out_valid_r;
  out_word_t out_data_r, out_data_nxt;

  always_comb begin
    logic signed [DIR_W-1:0] sx, sy, sz;
    sx = $signed(DIR_W'(qx));
    sy = $signed(DIR_W'(qy));
    sz = $signed(DIR_W'(qz));
    if (qx_side[1]) begin
      out_data_nxt.dir_x      = '0;
      out_data_nxt.dir_y      = '0;
      out_data_nxt.dir_z      = '0;
      out_data_nxt.degenerate = 1'b1;
    end else begin
      out_data_nxt.dir_x      = qx_side[0] ? -sx : sx;
      out_data_nxt.dir_y      = qy_neg ? -sy : sy;
      out_data_nxt.dir_z      = qz_neg ? -sz : sz;
      out_data_nxt.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= qx_vld;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("pixel word produced no result at the expected cycle");

  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result word without a matching pixel word");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.degenerate) |->
      (out_data.dir_x == 0 && out_data.dir_y == 0 && out_data.dir_z == 0))
    else $error("degenerate result carries a nonzero direction");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.degenerate) |->
      (out_data.dir_x <= 16384 && out_data.dir_x >= -16384 &&
       out_data.dir_y <= 16384 && out_data.dir_y >= -16384 &&
       out_data.dir_z <= 16384 && out_data.dir_z >= -16384))
    else $error("direction component outside unit range");
`endif

endmodule

// File: bench/tb_pinhole_view_ray_generator.sv
// Testbench for the pinhole view ray generator: checks every ray direction word.
`timescale 1ns / 1ps

// Self-checking bench. A driver takes pixel words from pending_pixels and
// presents them on the start/busy handshake, idling at a rate that changes
// per phase. Each accepted pixel is run through predict_ray(), which uses a
// shadow copy of the camera registers, and the predicted direction is queued.
// The monitor compares every out_valid word with the oldest prediction.
// Camera registers are rewritten only when no pixel is in flight.
module tb_pinhole_view_ray_generator;
  import pvrg_pkg::*;

  localparam int  CLK_HALF      = 5;
  localparam int  RESET_CYCLES  = 6;
  localparam int  ITEMS_PER_SET = 250;
  localparam int  NUM_SETTINGS  = 7;
  // Wait for the pipeline to drain at the end.
  localparam int  DRAIN_CYCLES  = 120;
  localparam int  CYCLE_LIMIT   = 200000;
  localparam int  MAX_REPORTS   = 10;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_word_t             in_data;
  logic                 out_valid;
  out_word_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CORNER_W-1:0]  cfg_data;

  pinhole_view_ray_generator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Shadow camera registers, updated on each accepted config write.
  logic [CORNER_W-1:0] cam_tl, cam_tr, cam_bl, cam_eye;
  logic [DIM_W-1:0]    cam_width, cam_height;

  in_word_t  pending_pixels[$];
  out_word_t ray_expected[$];
  int        sender_idle_pct;
  int        mismatch_count;
  int        rays_checked;
  int        degenerate_seen;
  int        pixels_sent;
  int        cycle_count;

  function automatic longint signed coord_of(logic [CORNER_W-1:0] r, int i);
    logic signed [COORD_BITS-1:0] c;
    c = r[i*COORD_BITS +: COORD_BITS];
    return longint'(c);
  endfunction

  function automatic longint unsigned dim_clamped(logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
    return d;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Unit view direction for one pixel under the shadow camera.
  function automatic out_word_t predict_ray(in_word_t px);
    out_word_t        res;
    longint signed    rx, ry, tl, tr, bl, e, v;
    logic [63:0]      mag[3];
    logic [63:0]      m, sum, len, q;
    logic [DIR_W-1:0] d[3];
    bit               neg[3];
    rx = longint'((64'(px.pixel_col) << 16) / dim_clamped(cam_width));
    ry = longint'((64'(px.pixel_row) << 16) / dim_clamped(cam_height));
    m = 0;
    for (int i = 0; i < 3; i++) begin
      tl = coord_of(cam_tl, i);
      tr = coord_of(cam_tr, i);
      bl = coord_of(cam_bl, i);
      e  = coord_of(cam_eye, i);
      v  = (tl - e) * 65536 + (tr - tl) * rx + (bl - tl) * ry;
      neg[i] = v < 0;
      mag[i] = neg[i] ? 64'(-v) : 64'(v);
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      res = '0;
      res.degenerate = 1'b1;
      return res;
    end
    while (m >= (64'd1 << 31)) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (m < (64'd1 << 30)) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * 16384 + (len >> 1)) / len;
      d[i] = neg[i] ? DIR_W'(-q) : DIR_W'(q);
    end
    res.dir_x = d[0];
    res.dir_y = d[1];
    res.dir_z = d[2];
    res.degenerate = 1'b0;
    return res;
  endfunction

  // Track config writes exactly as the block sees them.
  always @(posedge clk) begin
    if (!rst_n) begin
      cam_tl <= '0; cam_tr <= '0; cam_bl <= '0; cam_eye <= '0;
      cam_width <= 13'd640; cam_height <= 13'd480;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TOP_LEFT:    cam_tl <= cfg_data;
        REG_TOP_RIGHT:   cam_tr <= cfg_data;
        REG_BOTTOM_LEFT: cam_bl <= cfg_data;
        REG_EYE:         cam_eye <= cfg_data;
        REG_WIDTH:       cam_width <= cfg_data[DIM_W-1:0];
        REG_HEIGHT:      cam_height <= cfg_data[DIM_W-1:0];
        default: ;  // spare indexes: drop the write
      endcase
    end
  end

  // Driver: predict on acceptance, then hold, advance or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        ray_expected.push_back(predict_ray(in_data));
        pixels_sent++;
      end
      if (start && busy) begin
        // hold the current word until it is taken
      end else if (pending_pixels.size() > 0 &&
                   $urandom_range(99, 0) >= sender_idle_pct) begin
        in_data <= pending_pixels.pop_front();
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed word must match the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (ray_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected ray word %h with none pending", out_data);
      end else begin
        out_word_t want;
        want = ray_expected.pop_front();
        rays_checked++;
        if (out_data.degenerate) degenerate_seen++;
        if (out_data.dir_x !== want.dir_x || out_data.dir_y !== want.dir_y ||
            out_data.dir_z !== want.dir_z || out_data.degenerate !== want.degenerate) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("ray mismatch: want x=%0d y=%0d z=%0d deg=%b got x=%0d y=%0d z=%0d deg=%b",
                     want.dir_x, want.dir_y, want.dir_z, want.degenerate,
                     out_data.dir_x, out_data.dir_y, out_data.dir_z, out_data.degenerate);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_pinhole_view_ray_generator failed");
      $finish;
    end
  end

  // One register write; returns right after the edge that accepts it.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CORNER_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // Write all six camera registers, starting right after a rising edge.
  task automatic load_camera(logic [CORNER_W-1:0] tl, logic [CORNER_W-1:0] tr,
                             logic [CORNER_W-1:0] bl, logic [CORNER_W-1:0] eye,
                             logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    write_reg(REG_TOP_LEFT, tl);
    write_reg(REG_TOP_RIGHT, tr);
    write_reg(REG_BOTTOM_LEFT, bl);
    write_reg(REG_EYE, eye);
    // upper data bits beyond the 13 bit dimension must be ignored
    write_reg(REG_WIDTH, {$urandom, 16'h0} | 48'(w));
    write_reg(REG_HEIGHT, 48'(h));
    cfg_valid <= 1'b0;
  endtask

  // Wait until no pixel is queued, presented or in flight.
  task automatic drain_pipe();
    @(negedge clk);
    while (pending_pixels.size() != 0 || start || ray_expected.size() != 0)
      @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [CORNER_W-1:0] rand_point();
    return {16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  function automatic in_word_t pixel(int unsigned c, int unsigned r);
    in_word_t p;
    p.pixel_col = PIX_W'(c);
    p.pixel_row = PIX_W'(r);
    return p;
  endfunction

  initial begin
    logic [CORNER_W-1:0] tl, tr, bl, eye;
    logic [DIM_W-1:0]    w, h;
    int unsigned         wc, hc;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_TOP_LEFT;
    cfg_data <= '0;
    sender_idle_pct = 0;
    mismatch_count = 0; rays_checked = 0; degenerate_seen = 0;
    pixels_sent = 0; cycle_count = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset camera is all zero, so every ray is degenerate.
    pending_pixels.push_back(pixel(0, 0));
    pending_pixels.push_back(pixel(4095, 4095));
    pending_pixels.push_back(pixel(639, 479));
    drain_pipe();

    // Eye on the top-left corner: pixel 0,0 has zero length. Width zero acts
    // as one, an oversized height saturates, spare indexes are dropped.
    load_camera(48'h0100_0200_FF00, 48'h0100_0200_0300, 48'h0100_FC00_FF00,
                48'h0100_0200_FF00, 13'd0, 13'd8191);
    write_reg(REG_SPARE_6, '1);
    write_reg(REG_SPARE_7, '1);
    cfg_valid <= 1'b0;
    pending_pixels.push_back(pixel(0, 0));
    pending_pixels.push_back(pixel(1, 0));
    pending_pixels.push_back(pixel(0, 1));
    pending_pixels.push_back(pixel(4095, 0));
    pending_pixels.push_back(pixel(0, 4095));
    pending_pixels.push_back(pixel(4095, 4095));
    pending_pixels.push_back(pixel(2048, 2048));
    drain_pipe();

    // Extreme corner values pushing the widest span, beyond-screen pixels.
    load_camera(48'h7FFF_7FFF_7FFF, 48'h8000_7FFF_8000, 48'h7FFF_8000_8000,
                48'h8000_8000_8000, 13'd4096, 13'd1);
    pending_pixels.push_back(pixel(0, 0));
    pending_pixels.push_back(pixel(4095, 0));
    pending_pixels.push_back(pixel(0, 4095));
    pending_pixels.push_back(pixel(4095, 4095));
    pending_pixels.push_back(pixel(12'hAAA, 12'h555));
    pending_pixels.push_back(pixel(12'h555, 12'hAAA));
    pending_pixels.push_back(pixel(1, 1));
    drain_pipe();

    // Random phases, each under its own camera.
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      tl = rand_point(); tr = rand_point(); bl = rand_point(); eye = rand_point();
      w = 13'($urandom_range(4096, 1));
      h = 13'($urandom_range(4096, 1));
      case (s)
        0: begin w = 13'd640; h = 13'd480; end
        1: begin w = 13'd1; h = 13'd4096; end
        2: begin w = 13'($urandom_range(8191, 4097)); h = 13'd0; end
        3: begin
          w = 13'($urandom_range(64, 2)); h = 13'($urandom_range(64, 2));
          tl = 48'h8000_8000_8000; eye = 48'h7FFF_7FFF_7FFF;
        end
        4: begin tr = tl; bl = tl; end  // eye-to-screen offset only
        default: ;
      endcase
      load_camera(tl, tr, bl, eye, w, h);
      sender_idle_pct = (s < 3) ? 35 : (s < 5) ? 61 : 0;
      wc = dim_clamped(w);
      hc = dim_clamped(h);
      for (int i = 0; i < ITEMS_PER_SET; i++) begin
        if ($urandom_range(99, 0) < 80)
          pending_pixels.push_back(pixel($urandom_range(wc > 4095 ? 4095 : wc - 1, 0),
                                         $urandom_range(hc > 4095 ? 4095 : hc - 1, 0)));
        else
          pending_pixels.push_back(pixel($urandom, $urandom));
      end
      drain_pipe();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d pixels over %0d random cameras plus directed cases",
             pixels_sent, NUM_SETTINGS);
    $display("checked %0d rays (%0d degenerate), %0d mismatches, %0d left over",
             rays_checked, degenerate_seen, mismatch_count, ray_expected.size());
    if (mismatch_count == 0 && ray_expected.size() == 0) begin
      $display("tb_pinhole_view_ray_generator passed");
    end else begin
      $display("tb_pinhole_view_ray_generator failed");
    end
    $finish;
  end

endmodule

// File: pinhole_view_ray_generator.f
hdl/pvrg_pkg.sv
hdl/pvrg_div.sv
hdl/pvrg_isqrt.sv
hdl/pinhole_view_ray_generator.sv
bench/tb_pinhole_view_ray_generator.sv
